>>> hdl/rti_pkg.sv
`default_nettype none
// ============================================================================
// rti_pkg
// Shared widths, codes and types of the ray / triangle intersection pipeline.
// ============================================================================
package rti_pkg;

    localparam int FRAC_BITS = 10;

    // Q10.10 coordinate width and derived intermediate widths
    localparam int CW      = 21;
    localparam int G_W     = CW + 1;
    localparam int PRD_W   = 2 * CW;
    localparam int P_W     = PRD_W + 1 - FRAC_BITS;
    localparam int GPRD_W  = G_W + CW;
    localparam int Q_W     = GPRD_W + 1 - FRAC_BITS;
    localparam int EP_W    = CW + P_W;
    localparam int GP_W    = G_W + P_W;
    localparam int DQ_W    = CW + Q_W;
    localparam int DET_W   = EP_W + 2 - FRAC_BITS;
    localparam int UN_W    = GP_W + 2 - FRAC_BITS;
    localparam int VN_W    = DQ_W + 2 - FRAC_BITS;
    localparam int NEG_W   = UN_W + 1;
    localparam int TM_W    = VN_W;

    // Divider
    localparam int NUM_W   = 64;
    localparam int DEN_W   = DET_W;
    localparam int QUO_W   = CW;
    localparam int DIV_LAT = QUO_W + 1;

    // Barycentric / texture formats
    localparam int BW      = 17;
    localparam int ONE_FRAC = 16;
    localparam int TF_W    = 16;
    localparam int TEX_W   = 24;

    localparam logic signed [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

    // Configuration register indexes
    localparam logic [2:0] CFG_CORNER = 3'd0;
    localparam logic [2:0] CFG_EDGE1  = 3'd1;
    localparam logic [2:0] CFG_EDGE2  = 3'd2;
    localparam logic [2:0] CFG_NORMAL = 3'd3;
    localparam logic [2:0] CFG_TEX0   = 3'd4;
    localparam logic [2:0] CFG_TEX1   = 3'd5;
    localparam logic [2:0] CFG_TEX2   = 3'd6;
    localparam logic [2:0] CFG_LIMIT  = 3'd7;

    // Outcome codes
    localparam logic [2:0] OUT_HIT      = 3'd0;
    localparam logic [2:0] OUT_BACK     = 3'd1;
    localparam logic [2:0] OUT_PARALLEL = 3'd2;
    localparam logic [2:0] OUT_U_OUT    = 3'd3;
    localparam logic [2:0] OUT_V_OUT    = 3'd4;

    typedef struct packed {
        logic signed [CW-1:0] ox;
        logic signed [CW-1:0] oy;
        logic signed [CW-1:0] oz;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [CW-1:0] dz;
    } ray_t;

    typedef struct packed {
        logic [2:0] outcome;
        logic       tneg;
        ray_t       ray;
    } side_t;

endpackage
`default_nettype wire

>>> hdl/rti_div.sv
`default_nettype none
// ============================================================================
// rti_div
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ============================================================================
module rti_div
(
    input  wire logic                       clk,
    input  wire logic [rti_pkg::NUM_W-1:0] num,
    input  wire logic [rti_pkg::DEN_W-1:0] den,
    output logic      [rti_pkg::QUO_W-1:0] quo,
    output logic                           ovf
);

    localparam int NW = rti_pkg::NUM_W;
    localparam int DW = rti_pkg::DEN_W;
    localparam int QW = rti_pkg::QUO_W;
    localparam int XW = DW + QW;

    logic [NW-1:0] rem_reg [QW+1];
    logic [DW-1:0] den_reg [QW+1];
    logic [QW-1:0] quo_reg [QW+1];
    logic          ovf_reg [QW+1];

    logic          ovf_next;

    // overflow when the quotient does not fit in QW bits
    assign ovf_next = XW'(num) >= {den, {QW{1'b0}}};

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= num;
        den_reg[0] <= den;
        quo_reg[0] <= '0;
        ovf_reg[0] <= ovf_next;
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_step
        localparam int SH = QW - 1 - k;
        logic [XW:0]   trial_next;

        assign trial_next = (XW+1)'(rem_reg[k]) - ((XW+1)'(den_reg[k]) << SH);

        always_ff @(posedge clk)
        begin
            if (!trial_next[XW])
            begin
                rem_reg[k+1] <= trial_next[NW-1:0];
            end
            else
            begin
                rem_reg[k+1] <= rem_reg[k];
            end
            quo_reg[k+1] <= {quo_reg[k][QW-2:0], ~trial_next[XW]};
            den_reg[k+1] <= den_reg[k];
            ovf_reg[k+1] <= ovf_reg[k];
        end
    end

    assign quo = quo_reg[QW];
    assign ovf = ovf_reg[QW];

endmodule
`default_nettype wire

>>> hdl/ray_triangle_intersect_top.sv
`default_nettype none
// ============================================================================
// ray_triangle_intersect_top
// Moller-Trumbore ray / triangle test in signed fixed point, fully pipelined.
// ============================================================================
// Throughput: one ray per cycle; busy stays low, the pipeline never stalls.
// Depth is set by the three quotient dividers (u, v, t).
// Reset: asynchronous, active low; clears valid bits, done and triangle
// registers (parallel limit resets to 1).
// ============================================================================
module ray_triangle_intersect_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // ray channel
    input  wire logic        start,
    output logic             busy,
    input  wire logic signed [20:0] origin_x,
    input  wire logic signed [20:0] origin_y,
    input  wire logic signed [20:0] origin_z,
    input  wire logic signed [20:0] direction_x,
    input  wire logic signed [20:0] direction_y,
    input  wire logic signed [20:0] direction_z,
    // result channel
    output logic             done,
    output logic [2:0]       outcome,
    output logic signed [20:0] distance,
    output logic [16:0]      bary_u,
    output logic [16:0]      bary_v,
    output logic signed [20:0] point_x,
    output logic signed [20:0] point_y,
    output logic signed [20:0] point_z,
    output logic [16:0]      tex_s,
    output logic [16:0]      tex_t,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [62:0] cfg_data
);

    localparam int F    = rti_pkg::FRAC_BITS;
    localparam int CW   = rti_pkg::CW;
    localparam int BW   = rti_pkg::BW;
    localparam int TFW  = rti_pkg::TF_W;
    localparam int TXW  = rti_pkg::TEX_W;
    localparam int LAT  = rti_pkg::DIV_LAT;

    // ------------------------------------------------------------------
    // Triangle registers
    // ------------------------------------------------------------------
    logic [3*CW-1:0] corner_reg, edge1_reg, edge2_reg, normal_reg;
    logic [2*TXW-1:0] tex0_reg, tex1_reg, tex2_reg;
    logic [19:0]     limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_reg <= '0;
            edge1_reg  <= '0;
            edge2_reg  <= '0;
            normal_reg <= '0;
            tex0_reg   <= '0;
            tex1_reg   <= '0;
            tex2_reg   <= '0;
            limit_reg  <= 20'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rti_pkg::CFG_CORNER: corner_reg <= cfg_data;
                rti_pkg::CFG_EDGE1:  edge1_reg  <= cfg_data;
                rti_pkg::CFG_EDGE2:  edge2_reg  <= cfg_data;
                rti_pkg::CFG_NORMAL: normal_reg <= cfg_data;
                rti_pkg::CFG_TEX0:   tex0_reg   <= cfg_data[2*TXW-1:0];
                rti_pkg::CFG_TEX1:   tex1_reg   <= cfg_data[2*TXW-1:0];
                rti_pkg::CFG_TEX2:   tex2_reg   <= cfg_data[2*TXW-1:0];
                rti_pkg::CFG_LIMIT:  limit_reg  <= cfg_data[19:0];
                default:             limit_reg  <= limit_reg;
            endcase
        end
    end

    // unpack the triangle vectors
    logic signed [CW-1:0] v0 [3];
    logic signed [CW-1:0] e1 [3];
    logic signed [CW-1:0] e2 [3];
    logic signed [CW-1:0] nm [3];

    for (genvar k = 0; k < 3; k++)
    begin : g_unpack
        assign v0[k] = corner_reg[k*CW +: CW];
        assign e1[k] = edge1_reg[k*CW +: CW];
        assign e2[k] = edge2_reg[k*CW +: CW];
        assign nm[k] = normal_reg[k*CW +: CW];
    end

    // the pipeline takes a beat every cycle
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage A: d x e2 products, back-face dot, g = o - v0
    // ------------------------------------------------------------------
    localparam int PRD  = rti_pkg::PRD_W;
    localparam int BFW  = PRD + 2;
    localparam int GW   = rti_pkg::G_W;

    rti_pkg::ray_t        ray_in;
    logic signed [PRD-1:0] dxe_next [6];
    logic signed [BFW-1:0] bf_next;
    logic signed [GW-1:0]  g_next [3];

    assign ray_in = '{ox: origin_x, oy: origin_y, oz: origin_z,
                      dx: direction_x, dy: direction_y, dz: direction_z};

    assign dxe_next[0] = direction_y * e2[2];
    assign dxe_next[1] = direction_z * e2[1];
    assign dxe_next[2] = direction_z * e2[0];
    assign dxe_next[3] = direction_x * e2[2];
    assign dxe_next[4] = direction_x * e2[1];
    assign dxe_next[5] = direction_y * e2[0];

    assign bf_next = BFW'(direction_x * nm[0]) + BFW'(direction_y * nm[1])
                   + BFW'(direction_z * nm[2]);

    assign g_next[0] = GW'(origin_x) - GW'(v0[0]);
    assign g_next[1] = GW'(origin_y) - GW'(v0[1]);
    assign g_next[2] = GW'(origin_z) - GW'(v0[2]);

    logic                  a_valid_reg;
    rti_pkg::ray_t         a_ray_reg;
    logic signed [PRD-1:0] a_dxe_reg [6];
    logic                  a_bf_reg;
    logic signed [GW-1:0]  a_g_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        a_ray_reg <= ray_in;
        a_dxe_reg <= dxe_next;
        a_bf_reg  <= bf_next > 0;
        a_g_reg   <= g_next;
    end

    // ------------------------------------------------------------------
    // Stage B: p = (d x e2) >> F, g x e1 products
    // ------------------------------------------------------------------
    localparam int PW   = rti_pkg::P_W;
    localparam int GPRD = rti_pkg::GPRD_W;

    logic signed [PRD:0]    pd_next [3];
    logic signed [GPRD-1:0] gxe_next [6];

    assign pd_next[0] = (PRD+1)'(a_dxe_reg[0]) - (PRD+1)'(a_dxe_reg[1]);
    assign pd_next[1] = (PRD+1)'(a_dxe_reg[2]) - (PRD+1)'(a_dxe_reg[3]);
    assign pd_next[2] = (PRD+1)'(a_dxe_reg[4]) - (PRD+1)'(a_dxe_reg[5]);

    assign gxe_next[0] = a_g_reg[1] * e1[2];
    assign gxe_next[1] = a_g_reg[2] * e1[1];
    assign gxe_next[2] = a_g_reg[2] * e1[0];
    assign gxe_next[3] = a_g_reg[0] * e1[2];
    assign gxe_next[4] = a_g_reg[0] * e1[1];
    assign gxe_next[5] = a_g_reg[1] * e1[0];

    logic                   b_valid_reg;
    rti_pkg::ray_t          b_ray_reg;
    logic                   b_bf_reg;
    logic signed [PW-1:0]   b_p_reg [3];
    logic signed [GPRD-1:0] b_gxe_reg [6];
    logic signed [GW-1:0]   b_g_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_ray_reg <= a_ray_reg;
        b_bf_reg  <= a_bf_reg;
        for (int k = 0; k < 3; k++)
        begin
            b_p_reg[k] <= pd_next[k][PRD:F];
        end
        b_gxe_reg <= gxe_next;
        b_g_reg   <= a_g_reg;
    end

    // ------------------------------------------------------------------
    // Stage C: q = (g x e1) >> F, e1.p and g.p products
    // ------------------------------------------------------------------
    localparam int QW  = rti_pkg::Q_W;
    localparam int EPW = rti_pkg::EP_W;
    localparam int GPW = rti_pkg::GP_W;

    logic signed [GPRD:0]  qd_next [3];
    logic signed [EPW-1:0] ep_next [3];
    logic signed [GPW-1:0] gp_next [3];

    assign qd_next[0] = (GPRD+1)'(b_gxe_reg[0]) - (GPRD+1)'(b_gxe_reg[1]);
    assign qd_next[1] = (GPRD+1)'(b_gxe_reg[2]) - (GPRD+1)'(b_gxe_reg[3]);
    assign qd_next[2] = (GPRD+1)'(b_gxe_reg[4]) - (GPRD+1)'(b_gxe_reg[5]);

    for (genvar k = 0; k < 3; k++)
    begin : g_stage_c
        assign ep_next[k] = e1[k] * b_p_reg[k];
        assign gp_next[k] = b_g_reg[k] * b_p_reg[k];
    end

    logic                  c_valid_reg;
    rti_pkg::ray_t         c_ray_reg;
    logic                  c_bf_reg;
    logic signed [QW-1:0]  c_q_reg [3];
    logic signed [EPW-1:0] c_ep_reg [3];
    logic signed [GPW-1:0] c_gp_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c_ray_reg <= b_ray_reg;
        c_bf_reg  <= b_bf_reg;
        for (int k = 0; k < 3; k++)
        begin
            c_q_reg[k] <= qd_next[k][GPRD:F];
        end
        c_ep_reg <= ep_next;
        c_gp_reg <= gp_next;
    end

    // ------------------------------------------------------------------
    // Stage D: det, un; d.q and e2.q products
    // ------------------------------------------------------------------
    localparam int DETW = rti_pkg::DET_W;
    localparam int UNW  = rti_pkg::UN_W;
    localparam int VNW  = rti_pkg::VN_W;
    localparam int DQW  = rti_pkg::DQ_W;

    logic signed [EPW+1:0] det_sum;
    logic signed [GPW+1:0] un_sum;
    logic signed [DQW-1:0] dq_next [3];
    logic signed [DQW-1:0] eq_next [3];

    assign det_sum = (EPW+2)'(c_ep_reg[0]) + (EPW+2)'(c_ep_reg[1])
                   + (EPW+2)'(c_ep_reg[2]);
    assign un_sum  = (GPW+2)'(c_gp_reg[0]) + (GPW+2)'(c_gp_reg[1])
                   + (GPW+2)'(c_gp_reg[2]);

    assign dq_next[0] = c_ray_reg.dx * c_q_reg[0];
    assign dq_next[1] = c_ray_reg.dy * c_q_reg[1];
    assign dq_next[2] = c_ray_reg.dz * c_q_reg[2];

    for (genvar k = 0; k < 3; k++)
    begin : g_stage_d
        assign eq_next[k] = e2[k] * c_q_reg[k];
    end

    logic                   d_valid_reg;
    rti_pkg::ray_t          d_ray_reg;
    logic                   d_bf_reg;
    logic signed [DETW-1:0] d_det_reg;
    logic signed [UNW-1:0]  d_un_reg;
    logic signed [DQW-1:0]  d_dq_reg [3];
    logic signed [DQW-1:0]  d_eq_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else
        begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d_ray_reg <= c_ray_reg;
        d_bf_reg  <= c_bf_reg;
        d_det_reg <= det_sum[EPW+1:F];
        d_un_reg  <= un_sum[GPW+1:F];
        d_dq_reg  <= dq_next;
        d_eq_reg  <= eq_next;
    end

    // ------------------------------------------------------------------
    // Stage E: vn, tn
    // ------------------------------------------------------------------
    logic signed [DQW+1:0] vn_sum;
    logic signed [DQW+1:0] tn_sum;

    assign vn_sum = (DQW+2)'(d_dq_reg[0]) + (DQW+2)'(d_dq_reg[1])
                  + (DQW+2)'(d_dq_reg[2]);
    assign tn_sum = (DQW+2)'(d_eq_reg[0]) + (DQW+2)'(d_eq_reg[1])
                  + (DQW+2)'(d_eq_reg[2]);

    logic                   e_valid_reg;
    rti_pkg::ray_t          e_ray_reg;
    logic                   e_bf_reg;
    logic signed [DETW-1:0] e_det_reg;
    logic signed [UNW-1:0]  e_un_reg;
    logic signed [VNW-1:0]  e_vn_reg;
    logic signed [VNW-1:0]  e_tn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else
        begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e_ray_reg <= d_ray_reg;
        e_bf_reg  <= d_bf_reg;
        e_det_reg <= d_det_reg;
        e_un_reg  <= d_un_reg;
        e_vn_reg  <= vn_sum[DQW+1:F];
        e_tn_reg  <= tn_sum[DQW+1:F];
    end

    // ------------------------------------------------------------------
    // Stage F: fold the sign of det, classify the beat
    // ------------------------------------------------------------------
    localparam int NW  = rti_pkg::NEG_W;
    localparam int TMW = rti_pkg::TM_W;

    logic                   det_neg;
    logic [DETW-1:0]        detm_next;
    logic signed [NW-1:0]   un2, vn2, tn2;
    logic signed [NW:0]     uv_sum;
    logic signed [NW-1:0]   detm_s;
    logic [TMW-1:0]         tnm_next;
    logic [2:0]             outcome_next;

    assign det_neg   = e_det_reg < 0;
    assign detm_next = det_neg ? DETW'(-e_det_reg) : DETW'(e_det_reg);
    assign un2       = det_neg ? -NW'(e_un_reg) : NW'(e_un_reg);
    assign vn2       = det_neg ? -NW'(e_vn_reg) : NW'(e_vn_reg);
    assign tn2       = det_neg ? -NW'(e_tn_reg) : NW'(e_tn_reg);
    assign detm_s    = $signed(NW'(detm_next));
    assign uv_sum    = (NW+1)'(un2) + (NW+1)'(vn2);
    assign tnm_next  = tn2 < 0 ? TMW'(-tn2) : TMW'(tn2);

    always_comb
    begin
        if (e_bf_reg)
        begin
            outcome_next = rti_pkg::OUT_BACK;
        end
        else if (e_det_reg == 0 || detm_next < DETW'(limit_reg))
        begin
            outcome_next = rti_pkg::OUT_PARALLEL;
        end
        else if (un2 < 0 || un2 > detm_s)
        begin
            outcome_next = rti_pkg::OUT_U_OUT;
        end
        else if (vn2 < 0 || uv_sum > (NW+1)'(detm_s))
        begin
            outcome_next = rti_pkg::OUT_V_OUT;
        end
        else
        begin
            outcome_next = rti_pkg::OUT_HIT;
        end
    end

    logic                f_valid_reg;
    rti_pkg::side_t      f_side_reg;
    logic [DETW-1:0]     f_detm_reg;
    logic [DETW-1:0]     f_unm_reg;
    logic [DETW-1:0]     f_vnm_reg;
    logic [TMW-1:0]      f_tnm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f_side_reg <= '{outcome: outcome_next, tneg: tn2 < 0, ray: e_ray_reg};
        f_detm_reg <= detm_next;
        f_unm_reg  <= un2[DETW-1:0];
        f_vnm_reg  <= vn2[DETW-1:0];
        f_tnm_reg  <= tnm_next;
    end

    // ------------------------------------------------------------------
    // Dividers: u = un*2^16/det, v = vn*2^16/det, |t| = |tn|*2^F/det
    // ------------------------------------------------------------------
    localparam int NUMW = rti_pkg::NUM_W;
    localparam int QUOW = rti_pkg::QUO_W;

    logic [QUOW-1:0] quo_u, quo_v, quo_t;
    logic            ovf_u, ovf_v, ovf_t;

    rti_div u_div_u
    (
        .clk (clk),
        .num (NUMW'({f_unm_reg, {rti_pkg::ONE_FRAC{1'b0}}})),
        .den (f_detm_reg),
        .quo (quo_u),
        .ovf (ovf_u)
    );

    rti_div u_div_v
    (
        .clk (clk),
        .num (NUMW'({f_vnm_reg, {rti_pkg::ONE_FRAC{1'b0}}})),
        .den (f_detm_reg),
        .quo (quo_v),
        .ovf (ovf_v)
    );

    rti_div u_div_t
    (
        .clk (clk),
        .num (NUMW'({f_tnm_reg, {F{1'b0}}})),
        .den (f_detm_reg),
        .quo (quo_t),
        .ovf (ovf_t)
    );

    // hold the side fields alongside the divider stages
    rti_pkg::side_t side_reg [LAT];
    logic [LAT-1:0] side_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_valid_reg <= '0;
        end
        else
        begin
            side_valid_reg <= {side_valid_reg[LAT-2:0], f_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= f_side_reg;
        for (int k = 1; k < LAT; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage G: saturate t, form u, v and the first weight
    // ------------------------------------------------------------------
    rti_pkg::side_t  div_side;
    logic signed [CW-1:0] t_next;
    logic            t_big;

    assign div_side = side_reg[LAT-1];
    // in-range u and v never overflow: un, vn do not exceed det
    assign t_big = ovf_t || (quo_t > QUOW'(1 << (CW - 1)));

    always_comb
    begin
        if (!div_side.tneg)
        begin
            t_next = (ovf_t || quo_t[QUOW-1]) ? rti_pkg::SAT_MAX : $signed(quo_t);
        end
        else
        begin
            t_next = t_big ? rti_pkg::SAT_MIN : -$signed(quo_t);
        end
    end

    logic                 g_valid_reg;
    rti_pkg::side_t       g_side_reg;
    logic signed [CW-1:0] g_t_reg;
    logic [BW-1:0]        g_u_reg, g_v_reg, g_w_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg <= 1'b0;
        end
        else
        begin
            g_valid_reg <= side_valid_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        g_side_reg <= div_side;
        g_t_reg    <= t_next;
        g_u_reg    <= quo_u[BW-1:0] | BW'(ovf_u & ovf_v & 1'b0);
        g_v_reg    <= quo_v[BW-1:0];
        g_w_reg    <= BW'((1 << rti_pkg::ONE_FRAC) - quo_u[BW-1:0] - quo_v[BW-1:0]);
    end

    // ------------------------------------------------------------------
    // Stage H: t*d products and texture weight products
    // ------------------------------------------------------------------
    localparam int TPW = BW + TFW;

    logic                  h_valid_reg;
    rti_pkg::side_t        h_side_reg;
    logic signed [CW-1:0]  h_t_reg;
    logic [BW-1:0]         h_u_reg, h_v_reg;
    logic signed [PRD-1:0] h_td_reg [3];
    logic [TPW-1:0]        h_ts_reg [3];
    logic [TPW-1:0]        h_tt_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_valid_reg <= 1'b0;
        end
        else
        begin
            h_valid_reg <= g_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        h_side_reg  <= g_side_reg;
        h_t_reg     <= g_t_reg;
        h_u_reg     <= g_u_reg;
        h_v_reg     <= g_v_reg;
        h_td_reg[0] <= g_t_reg * g_side_reg.ray.dx;
        h_td_reg[1] <= g_t_reg * g_side_reg.ray.dy;
        h_td_reg[2] <= g_t_reg * g_side_reg.ray.dz;
        h_ts_reg[0] <= g_w_reg * tex0_reg[TFW-1:0];
        h_ts_reg[1] <= g_u_reg * tex1_reg[TFW-1:0];
        h_ts_reg[2] <= g_v_reg * tex2_reg[TFW-1:0];
        h_tt_reg[0] <= g_w_reg * tex0_reg[TXW +: TFW];
        h_tt_reg[1] <= g_u_reg * tex1_reg[TXW +: TFW];
        h_tt_reg[2] <= g_v_reg * tex2_reg[TXW +: TFW];
    end

    // ------------------------------------------------------------------
    // Stage I: hit point, texture sums, drop fields on a miss
    // ------------------------------------------------------------------
    localparam int PTW = PRD - F + 1;

    logic signed [PTW-1:0] pt_sum [3];
    logic signed [CW-1:0]  pt_sat [3];
    logic [TPW+1:0]        s_acc, t_acc;
    logic                  hit;

    // the shifted product keeps its sign
    assign pt_sum[0] = PTW'(h_side_reg.ray.ox) + PTW'($signed(h_td_reg[0][PRD-1:F]));
    assign pt_sum[1] = PTW'(h_side_reg.ray.oy) + PTW'($signed(h_td_reg[1][PRD-1:F]));
    assign pt_sum[2] = PTW'(h_side_reg.ray.oz) + PTW'($signed(h_td_reg[2][PRD-1:F]));

    for (genvar k = 0; k < 3; k++)
    begin : g_sat
        assign pt_sat[k] = (pt_sum[k] > PTW'(rti_pkg::SAT_MAX)) ? rti_pkg::SAT_MAX :
                           (pt_sum[k] < PTW'(rti_pkg::SAT_MIN)) ? rti_pkg::SAT_MIN :
                           pt_sum[k][CW-1:0];
    end

    assign s_acc = (TPW+2)'(h_ts_reg[0]) + (TPW+2)'(h_ts_reg[1]) + (TPW+2)'(h_ts_reg[2]);
    assign t_acc = (TPW+2)'(h_tt_reg[0]) + (TPW+2)'(h_tt_reg[1]) + (TPW+2)'(h_tt_reg[2]);
    assign hit   = h_side_reg.outcome == rti_pkg::OUT_HIT;

    logic done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= h_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        outcome  <= h_side_reg.outcome;
        distance <= hit ? h_t_reg : '0;
        bary_u   <= hit ? h_u_reg : '0;
        bary_v   <= hit ? h_v_reg : '0;
        point_x  <= hit ? pt_sat[0] : '0;
        point_y  <= hit ? pt_sat[1] : '0;
        point_z  <= hit ? pt_sat[2] : '0;
        tex_s    <= hit ? s_acc[rti_pkg::ONE_FRAC +: BW] : '0;
        tex_t    <= hit ? t_acc[rti_pkg::ONE_FRAC +: BW] : '0;
    end

    assign done = done_reg;

endmodule
`default_nettype wire
